// File: rtl/topo_sort_kahn_queue_defines.svh
// ----------------------------------------------------------------------------
// topo_sort_kahn_queue_defines
// Assertion macros shared by the topological sort RTL. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TOPO_SORT_KAHN_QUEUE_DEFINES_SVH
`define TOPO_SORT_KAHN_QUEUE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define TKS_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define TKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Types and constants shared by the topological sort block.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int NODE_W = 7;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_SORT = 1'b1;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
  } request_t;

  typedef struct packed {
    logic [NODE_W-1:0] ordered_node;
    logic              is_last;
    logic              all_ordered;
    logic              edge_dropped;
  } result_t;

  // Commands from the sequencer to the adjacency store.
  typedef struct packed {
    logic node_rd;
    logic edge_rd;
    logic append;
    logic clear;
  } adj_ctl_t;

  // Commands from the sequencer to the in-degree unit.
  typedef struct packed {
    logic rd;
    logic inc;
    logic dec;
    logic clear;
  } deg_ctl_t;

endpackage

// File: rtl/topo_sort_kahn_queue.sv
// ----------------------------------------------------------------------------
// topo_sort_kahn_queue
// Kahn topological sort over linked adjacency lists, run by a sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An edge item appends
// the target to the source's list, or is dropped if it is out of range or
// over capacity. A sort item rebuilds the in-degrees from the lists, seeds a
// ready queue with the zero in-degree nodes in ascending order, then pops
// nodes and walks their successors. Every step goes through one memory read
// port and one shared counter unit, so a sort does one step at a time from its
// accepting edge to the last result. Results leave on result with result_valid
// high for one cycle each. A result goes out one pop late, so the last one can
// carry is_last and all_ordered; a run that orders nothing gives one result
// with ordered_node zero. The receiver cannot stall. busy falls in the cycle
// that shows the final result; the graph store is then empty. The user must
// write the node count through cfg_we and cfg_data only while the block is
// idle; the block does not enforce this. Reset empties the graph and sets the
// node count to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "topo_sort_kahn_queue_defines.svh"

module topo_sort_kahn_queue #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  tks_pkg::request_t          request,
  output logic                       busy,
  input  logic                       cfg_we,
  input  logic [tks_pkg::NODE_W-1:0] cfg_data,
  output tks_pkg::result_t           result,
  output logic                       result_valid
);
  import tks_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SW = $clog2(MAX_EDGES + 1);
  localparam int QW = NW + 1;
  localparam logic [NODE_W-1:0] MAX_NODES_ID = NODE_W'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_SCAN_NODE, S_HEAD, S_EDGE, S_UPD,
    S_SEED_RD, S_SEED_CHK, S_POP, S_POP_WAIT, S_FINISH
  } state_t;

  state_t            state;
  logic              walk;
  logic [NW-1:0]     scan_idx;
  logic [EW-1:0]     cur_e;
  logic [EW-1:0]     last_e;
  logic [EW-1:0]     nxt_e;
  logic [NODE_W-1:0] dest_d;
  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] app_dst;
  logic [SW-1:0]     edges_stored;
  logic              drop;
  logic [NODE_W-1:0] node_count;
  logic [QW-1:0]     qhead;
  logic [QW-1:0]     qtail;
  logic [NODE_W-1:0] fifo_mem [MAX_NODES];
  logic [NODE_W-1:0] fifo_q;
  logic [NODE_W-1:0] pend_node;
  logic              pend_vld;
  logic [NODE_W-1:0] emitted;

  adj_ctl_t          adj_ctl;
  deg_ctl_t          deg_ctl;
  logic [NODE_W-1:0] node_sel;
  logic [NODE_W-1:0] node_m1;
  logic [NODE_W-1:0] dq_m1;
  logic [NODE_W-1:0] dd_m1;
  logic [NODE_W-1:0] n_use;
  logic [NODE_W-1:0] n_m1;
  logic [NW-1:0]     n_last;
  logic [NODE_W-1:0] scan_id;
  logic [NW-1:0]     node_idx;
  logic [EW-1:0]     edge_idx;
  logic [NW-1:0]     deg_rd_idx;
  logic [EW-1:0]     head_q;
  logic [EW-1:0]     tail_q;
  logic              head_vld_q;
  logic [NODE_W-1:0] dest_q;
  logic [EW-1:0]     next_q;
  logic [SW-1:0]     deg_count;
  logic              d_in_range;
  logic              edge_ok;
  logic              accept;
  logic              list_end;
  logic              push_en;
  logic [NODE_W-1:0] push_node;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (node_count > MAX_NODES_ID) begin
      n_use = MAX_NODES_ID;
    end else if (node_count == '0) begin
      n_use = NODE_W'(1);
    end else begin
      n_use = node_count;
    end
  end

  assign n_m1    = n_use - NODE_W'(1);
  assign n_last  = n_m1[NW-1:0];
  assign scan_id = NODE_W'(scan_idx) + NODE_W'(1);
  assign dq_m1   = dest_q - NODE_W'(1);
  assign dd_m1   = dest_d - NODE_W'(1);
  assign node_m1 = node_sel - NODE_W'(1);
  assign node_idx = node_m1[NW-1:0];

  assign d_in_range = (dest_q != '0) && (dest_q <= n_use);
  assign edge_ok = (request.source_node != '0) && (request.source_node <= n_use) &&
                   (request.target_node != '0) && (request.target_node <= n_use) &&
                   (edges_stored < SW'(MAX_EDGES));

  always_comb begin
    adj_ctl    = '0;
    deg_ctl    = '0;
    node_sel   = request.source_node;
    edge_idx   = head_q;
    deg_rd_idx = dq_m1[NW-1:0];
    push_en    = 1'b0;
    push_node  = dest_d;
    list_end   = 1'b0;
    case (state)
      S_IDLE: begin
        adj_ctl.node_rd = start;
      end
      S_APPEND: begin
        adj_ctl.append = 1'b1;
        node_sel = src_node;
      end
      S_SCAN_NODE: begin
        adj_ctl.node_rd = 1'b1;
        node_sel = scan_id;
      end
      S_POP_WAIT: begin
        adj_ctl.node_rd = 1'b1;
        node_sel = fifo_q;
      end
      S_HEAD: begin
        adj_ctl.edge_rd = head_vld_q;
        list_end = !head_vld_q;
      end
      S_EDGE: begin
        deg_ctl.rd = d_in_range;
        adj_ctl.edge_rd = !d_in_range && (cur_e != last_e);
        edge_idx = next_q;
        list_end = !d_in_range && (cur_e == last_e);
      end
      S_UPD: begin
        deg_ctl.inc = !walk;
        deg_ctl.dec = walk && (deg_count != '0);
        push_en = walk && (deg_count == SW'(1));
        adj_ctl.edge_rd = (cur_e != last_e);
        edge_idx = nxt_e;
        list_end = (cur_e == last_e);
      end
      S_SEED_RD: begin
        deg_ctl.rd = 1'b1;
        deg_rd_idx = scan_idx;
      end
      S_SEED_CHK: begin
        push_en = (deg_count == '0);
        push_node = scan_id;
      end
      S_FINISH: begin
        adj_ctl.clear = 1'b1;
        deg_ctl.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tks_adj_store #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_adj (
    .clk       (clk),
    .rst       (rst),
    .ctl       (adj_ctl),
    .node_idx  (node_idx),
    .edge_idx  (edge_idx),
    .app_edge  (edges_stored[EW-1:0]),
    .app_dest  (app_dst),
    .head_q    (head_q),
    .tail_q    (tail_q),
    .head_vld_q(head_vld_q),
    .dest_q    (dest_q),
    .next_q    (next_q)
  );

  tks_degree #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_deg (
    .clk   (clk),
    .rst   (rst),
    .ctl   (deg_ctl),
    .rd_idx(deg_rd_idx),
    .wr_idx(dd_m1[NW-1:0]),
    .count (deg_count)
  );

  // Ready queue: each node enters at most once per run, so it never wraps.
  always_ff @(posedge clk) begin
    if (push_en) begin
      fifo_mem[qtail[NW-1:0]] <= push_node;
    end
    if (state == S_POP && qhead != qtail) begin
      fifo_q <= fifo_mem[qhead[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      walk         <= 1'b0;
      scan_idx     <= '0;
      edges_stored <= '0;
      drop         <= 1'b0;
      node_count   <= NODE_COUNT_RESET;
      qhead        <= '0;
      qtail        <= '0;
      pend_vld     <= 1'b0;
      emitted      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (push_en) begin
        qtail <= qtail + QW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.req_type == REQ_EDGE) begin
              if (edge_ok) begin
                src_node <= request.source_node;
                app_dst  <= request.target_node;
                state    <= S_APPEND;
              end else begin
                drop <= 1'b1;
              end
            end else begin
              walk     <= 1'b0;
              scan_idx <= '0;
              qhead    <= '0;
              qtail    <= '0;
              emitted  <= '0;
              pend_vld <= 1'b0;
              state    <= S_SCAN_NODE;
            end
          end
        end
        S_APPEND: begin
          edges_stored <= edges_stored + SW'(1);
          state <= S_IDLE;
        end
        S_SCAN_NODE: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          cur_e  <= head_q;
          last_e <= tail_q;
          state  <= S_EDGE;
        end
        S_EDGE: begin
          nxt_e  <= next_q;
          dest_d <= dest_q;
          if (d_in_range) begin
            state <= S_UPD;
          end else begin
            cur_e <= next_q;
          end
        end
        S_UPD: begin
          cur_e <= nxt_e;
          state <= S_EDGE;
        end
        S_SEED_RD: begin
          state <= S_SEED_CHK;
        end
        S_SEED_CHK: begin
          if (scan_idx == n_last) begin
            walk  <= 1'b1;
            state <= S_POP;
          end else begin
            scan_idx <= scan_idx + NW'(1);
            state <= S_SEED_RD;
          end
        end
        S_POP: begin
          if (qhead == qtail) begin
            state <= S_FINISH;
          end else begin
            qhead <= qhead + QW'(1);
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          // The previous node goes out now that it is known not to be last.
          if (pend_vld) begin
            result_valid <= 1'b1;
            result <= '{ordered_node: pend_node, is_last: 1'b0,
                        all_ordered: 1'b0, edge_dropped: drop};
          end
          pend_node <= fifo_q;
          pend_vld  <= 1'b1;
          emitted   <= emitted + NODE_W'(1);
          state     <= S_HEAD;
        end
        S_FINISH: begin
          result_valid <= 1'b1;
          if (pend_vld) begin
            result <= '{ordered_node: pend_node, is_last: 1'b1,
                        all_ordered: (emitted == n_use), edge_dropped: drop};
          end else begin
            result <= '{ordered_node: '0, is_last: 1'b1,
                        all_ordered: 1'b0, edge_dropped: drop};
          end
          drop         <= 1'b0;
          edges_stored <= '0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // End of an adjacency list: the next node of the rebuild, or the next pop.
      if (list_end) begin
        if (walk) begin
          state <= S_POP;
        end else if (scan_idx == n_last) begin
          scan_idx <= '0;
          state <= S_SEED_RD;
        end else begin
          scan_idx <= scan_idx + NW'(1);
          state <= S_SCAN_NODE;
        end
      end
    end
  end

  `TKS_ASSERT_ALW(a_queue_order, qhead <= qtail, "ready queue read passed its write")
  `TKS_ASSERT_ALW(a_edges_cap, edges_stored <= SW'(MAX_EDGES), "edge count over capacity")
  `TKS_ASSERT_IMP(a_last_ends_run, result_valid, busy == !result.is_last, "last result and busy disagree")
  `TKS_ASSERT_IMP(a_null_is_last, result_valid && result.ordered_node == '0, result.is_last, "null result before the end")
  `TKS_ASSERT_NXT(a_edge_append, accept && request.req_type == REQ_EDGE && edge_ok, state == S_APPEND, "valid edge not appended")

endmodule

// File: rtl/tks_adj_store.sv
// ----------------------------------------------------------------------------
// tks_adj_store
// Linked adjacency lists: edge target and link memories, per-node head and
// tail memories, and head valid bits that all clear at once.
// ----------------------------------------------------------------------------
module tks_adj_store #(
  parameter int  MAX_NODES = 64,
  parameter int  MAX_EDGES = 256,
  localparam int NW = $clog2(MAX_NODES),
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tks_pkg::adj_ctl_t         ctl,
  input  logic [NW-1:0]             node_idx,
  input  logic [EW-1:0]             edge_idx,
  input  logic [EW-1:0]             app_edge,
  input  logic [tks_pkg::NODE_W-1:0] app_dest,
  output logic [EW-1:0]             head_q,
  output logic [EW-1:0]             tail_q,
  output logic                      head_vld_q,
  output logic [tks_pkg::NODE_W-1:0] dest_q,
  output logic [EW-1:0]             next_q
);
  import tks_pkg::*;

  logic [NODE_W-1:0]    dest_mem [MAX_EDGES];
  logic [EW-1:0]        next_mem [MAX_EDGES];
  logic [EW-1:0]        head_mem [MAX_NODES];
  logic [EW-1:0]        tail_mem [MAX_NODES];
  logic [MAX_NODES-1:0] head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      head_vld_q <= 1'b0;
    end else begin
      if (ctl.clear) begin
        head_valid <= '0;
      end else if (ctl.append) begin
        head_valid[node_idx] <= 1'b1;
      end
      if (ctl.node_rd) begin
        head_vld_q <= head_valid[node_idx];
      end
    end
  end

  // An append relies on the head and tail of the same node having been read
  // in the cycle before.
  always_ff @(posedge clk) begin
    if (ctl.node_rd) begin
      head_q <= head_mem[node_idx];
      tail_q <= tail_mem[node_idx];
    end
    if (ctl.edge_rd) begin
      dest_q <= dest_mem[edge_idx];
      next_q <= next_mem[edge_idx];
    end
    if (ctl.append) begin
      dest_mem[app_edge] <= app_dest;
      tail_mem[node_idx] <= app_edge;
      if (head_vld_q) begin
        next_mem[tail_q] <= app_edge;
      end else begin
        head_mem[node_idx] <= app_edge;
      end
    end
  end

endmodule

// File: rtl/tks_degree.sv
// ----------------------------------------------------------------------------
// tks_degree
// In-degree counters with a shared increment and decrement unit. A count is
// read into a register, then written back one up or one down.
// ----------------------------------------------------------------------------
module tks_degree #(
  parameter int  MAX_NODES = 64,
  parameter int  MAX_EDGES = 256,
  localparam int NW = $clog2(MAX_NODES),
  localparam int DW = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  tks_pkg::deg_ctl_t ctl,
  input  logic [NW-1:0]     rd_idx,
  input  logic [NW-1:0]     wr_idx,
  output logic [DW-1:0]     count
);
  import tks_pkg::*;

  logic [DW-1:0]        cnt_mem [MAX_NODES];
  logic [MAX_NODES-1:0] valid;
  logic [DW-1:0]        rdata;
  logic                 rvld;
  logic [DW-1:0]        upd;

  // Entries not written since the last clear read as zero.
  assign count = rvld ? rdata : '0;
  assign upd   = count + (ctl.dec ? {DW{1'b1}} : DW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvld  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.inc || ctl.dec) begin
        valid[wr_idx] <= 1'b1;
      end
      if (ctl.rd) begin
        rvld <= valid[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= cnt_mem[rd_idx];
    end
    if (ctl.inc || ctl.dec) begin
      cnt_mem[wr_idx] <= upd;
    end
  end

endmodule
